### design/plle_pkg.sv
`timescale 1ns / 1ps

package plle_pkg;

    localparam int DEFAULT_LIST_DEPTH  = 32;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 6;
    localparam int ITEM_W     = 32;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_POS  = 3'd2,
        CMD_DEL_POS  = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_RANGE = 2'd2,
        RES_EMPTY = 2'd3
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_HEAD,
        ST_INS_TAIL,
        ST_WALK,
        ST_INS_MID_A,
        ST_INS_MID_B,
        ST_DEL_HEAD,
        ST_DEL_STEP,
        ST_DEL_LINK,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_CUR,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_START,
        OP_WALK,
        OP_INS_HEAD,
        OP_INS_TAIL,
        OP_INS_MID_A,
        OP_INS_MID_B,
        OP_DEL_HEAD,
        OP_DEL_STEP,
        OP_DEL_LINK,
        OP_RD_ITEM,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        rd_sel_t rd_sel;
        result_t result;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic pos_zero;
        logic pos_one;
        logic pos_over_ins;
        logic pos_over_del;
        logic pos_append;
        logic steps_zero;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

### design/positional_linked_list_engine_core.sv
`timescale 1ns / 1ps

// Channel  Handshake           Payload
// s_       s_valid / s_ready   s_cmd, s_position, s_item_value
// m_       m_valid / m_ready   m_out_value, m_out_index, m_status, m_last, m_list_count
//
// One command is handled at a time. Rejected commands, unknown codes and a read out of an
// empty list go from decode straight to the result, while head and tail inserts first
// update the list. Positional insert and delete walk the link memory one element per cycle,
// and a read out gives one element per cycle while the result output is free; a stalled
// result holds the read out. Reset empties the list at once. A command whose result cannot
// yet be loaded keeps s_ready low.

module positional_linked_list_engine_core #(
    parameter int LIST_DEPTH  = plle_pkg::DEFAULT_LIST_DEPTH,
    parameter int VALUE_WIDTH = plle_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [plle_pkg::CMD_W-1:0]    s_cmd,
    input  logic        [plle_pkg::POS_W-1:0]    s_position,
    input  logic signed [plle_pkg::ITEM_W-1:0]   s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [plle_pkg::ITEM_W-1:0]   m_out_value,
    output logic        [plle_pkg::IDX_W-1:0]    m_out_index,
    output logic        [plle_pkg::STATUS_W-1:0] m_status,
    output logic                                m_last,
    output logic        [plle_pkg::IDX_W-1:0]    m_list_count
);

    import plle_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    plle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    plle_dpath #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_index  (m_out_index),
        .m_status     (m_status),
        .m_last       (m_last),
        .m_list_count (m_list_count),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule

### design/plle_ram.sv
`timescale 1ns / 1ps

module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/plle_ctrl.sv
`timescale 1ns / 1ps

module plle_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  plle_pkg::dp_status_t sts,
    output plle_pkg::ctrl_cmd_t  ctl
);

    import plle_pkg::*;

    state_t  state_reg, state_next;
    result_t result_reg, result_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            result_reg <= RES_OK;
        end else begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                result_next = RES_OK;
                state_next  = ST_RESULT;
                unique case (sts.cmd)
                    CMD_READ: begin
                        if (sts.empty) begin
                            result_next = RES_EMPTY;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    CMD_INS_HEAD: begin
                        if (sts.full) begin
                            result_next = RES_FULL;
                        end else begin
                            state_next = ST_INS_HEAD;
                        end
                    end
                    CMD_INS_TAIL: begin
                        if (sts.full) begin
                            result_next = RES_FULL;
                        end else if (sts.empty) begin
                            state_next = ST_INS_HEAD;
                        end else begin
                            state_next = ST_INS_TAIL;
                        end
                    end
                    CMD_INS_POS: begin
                        if (sts.full) begin
                            result_next = RES_FULL;
                        end else if (sts.pos_zero || sts.pos_over_ins) begin
                            result_next = RES_RANGE;
                        end else if (sts.pos_one) begin
                            state_next = ST_INS_HEAD;
                        end else if (sts.pos_append) begin
                            state_next = ST_INS_TAIL;
                        end else begin
                            state_next = ST_WALK;
                        end
                    end
                    CMD_DEL_POS: begin
                        if (sts.pos_zero || sts.pos_over_del) begin
                            result_next = RES_RANGE;
                        end else begin
                            state_next = ST_WALK;
                        end
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_INS_HEAD, ST_INS_TAIL, ST_INS_MID_B, ST_DEL_HEAD, ST_DEL_LINK: begin
                state_next = ST_RESULT;
            end
            ST_WALK: begin
                if (sts.steps_zero) begin
                    if (sts.cmd == CMD_INS_POS) begin
                        state_next = ST_INS_MID_A;
                    end else if (sts.pos_one) begin
                        state_next = ST_DEL_HEAD;
                    end else begin
                        state_next = ST_DEL_STEP;
                    end
                end
            end
            ST_INS_MID_A: begin
                state_next = ST_INS_MID_B;
            end
            ST_DEL_STEP: begin
                state_next = ST_DEL_LINK;
            end
            ST_READ: begin
                if (sts.out_free && sts.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        ctl.op     = OP_NONE;
        ctl.rd_sel = RD_CUR;
        ctl.result = result_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.op = OP_CAPTURE;
                end
            end
            ST_DECODE: begin
                ctl.op     = OP_START;
                ctl.rd_sel = RD_HEAD;
            end
            ST_INS_HEAD: begin
                ctl.op = OP_INS_HEAD;
            end
            ST_INS_TAIL: begin
                ctl.op = OP_INS_TAIL;
            end
            ST_WALK: begin
                if (!sts.steps_zero) begin
                    ctl.op     = OP_WALK;
                    ctl.rd_sel = RD_NEXT;
                end
            end
            ST_INS_MID_A: begin
                ctl.op = OP_INS_MID_A;
            end
            ST_INS_MID_B: begin
                ctl.op = OP_INS_MID_B;
            end
            ST_DEL_HEAD: begin
                ctl.op = OP_DEL_HEAD;
            end
            ST_DEL_STEP: begin
                ctl.op     = OP_DEL_STEP;
                ctl.rd_sel = RD_NEXT;
            end
            ST_DEL_LINK: begin
                ctl.op = OP_DEL_LINK;
            end
            ST_READ: begin
                if (sts.out_free) begin
                    ctl.op = OP_RD_ITEM;
                    if (!sts.idx_last) begin
                        ctl.rd_sel = RD_NEXT;
                    end
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    ctl.op = OP_RESULT;
                end
            end
            default: begin
                ctl.op = OP_NONE;
            end
        endcase
    end

endmodule

### design/plle_dpath.sv
`timescale 1ns / 1ps

module plle_dpath #(
    parameter int LIST_DEPTH  = plle_pkg::DEFAULT_LIST_DEPTH,
    parameter int VALUE_WIDTH = plle_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic        [plle_pkg::CMD_W-1:0]    s_cmd,
    input  logic        [plle_pkg::POS_W-1:0]    s_position,
    input  logic signed [plle_pkg::ITEM_W-1:0]   s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [plle_pkg::ITEM_W-1:0]   m_out_value,
    output logic        [plle_pkg::IDX_W-1:0]    m_out_index,
    output logic        [plle_pkg::STATUS_W-1:0] m_status,
    output logic                                m_last,
    output logic        [plle_pkg::IDX_W-1:0]    m_list_count,
    input  plle_pkg::ctrl_cmd_t                 ctl,
    output plle_pkg::dp_status_t                sts
);

    import plle_pkg::*;

    localparam int SLOT_W = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int PW     = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    cmd_t                    cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ITEM_W-1:0]       val_reg, val_next;
    logic [SLOT_W-1:0]       head_reg, head_next;
    logic [SLOT_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LIST_DEPTH-1:0]   free_map_reg, free_map_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       prev_reg, prev_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;

    logic                    out_valid_reg, out_valid_next;
    logic [ITEM_W-1:0]       out_value_reg, out_value_next;
    logic [IDX_W-1:0]        out_index_reg, out_index_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;
    logic [IDX_W-1:0]        out_count_reg, out_count_next;

    logic                    val_we;
    logic [SLOT_W-1:0]       val_waddr;
    logic [VALUE_WIDTH-1:0]  val_wdata;
    logic [VALUE_WIDTH-1:0]  val_rdata;
    logic                    nxt_we;
    logic [SLOT_W-1:0]       nxt_waddr;
    logic [SLOT_W-1:0]       nxt_wdata;
    logic [SLOT_W-1:0]       nxt_rdata;
    logic [SLOT_W-1:0]       rd_addr;

    logic [PW-1:0]           pos_x;
    logic [PW-1:0]           cnt_x;
    logic                    out_free;

    plle_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    plle_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (LIST_DEPTH)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    assign pos_x    = PW'(pos_reg);
    assign cnt_x    = PW'(count_reg);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        sts.cmd          = cmd_reg;
        sts.empty        = (count_reg == '0);
        sts.full         = (count_reg == CNT_W'(LIST_DEPTH));
        sts.pos_zero     = (pos_reg == '0);
        sts.pos_one      = (pos_reg == POS_W'(1));
        sts.pos_over_ins = (pos_x > cnt_x + PW'(1));
        sts.pos_over_del = (pos_x > cnt_x);
        sts.pos_append   = (pos_x == cnt_x + PW'(1));
        sts.steps_zero   = (steps_reg == '0);
        sts.idx_last     = (idx_reg == count_reg);
        sts.out_free     = out_free;
    end

    always_comb begin
        unique case (ctl.rd_sel)
            RD_HEAD: rd_addr = head_reg;
            RD_NEXT: rd_addr = nxt_rdata;
            default: rd_addr = cur_reg;
        endcase
    end

    always_comb begin
        free_idx_next = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (free_map_reg[i]) begin
                free_idx_next = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_map_next   = free_map_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        val_we          = 1'b0;
        val_waddr       = free_idx_reg;
        val_wdata       = VALUE_WIDTH'(val_reg);
        nxt_we          = 1'b0;
        nxt_waddr       = free_idx_reg;
        nxt_wdata       = head_reg;

        case (ctl.op)
            OP_CAPTURE: begin
                cmd_next = cmd_t'(s_cmd);
                pos_next = s_position;
                val_next = $unsigned(s_item_value);
            end
            OP_START: begin
                cur_next   = head_reg;
                steps_next = (pos_reg < POS_W'(2)) ? '0 : CNT_W'(pos_reg - POS_W'(2));
                idx_next   = CNT_W'(1);
            end
            OP_WALK: begin
                cur_next   = nxt_rdata;
                steps_next = steps_reg - CNT_W'(1);
            end
            OP_INS_HEAD: begin
                val_we                      = 1'b1;
                nxt_we                      = 1'b1;
                free_map_next[free_idx_reg] = 1'b0;
                head_next                   = free_idx_reg;
                if (count_reg == '0) begin
                    tail_next = free_idx_reg;
                end
                count_next = count_reg + CNT_W'(1);
            end
            OP_INS_TAIL: begin
                val_we                      = 1'b1;
                nxt_we                      = 1'b1;
                nxt_waddr                   = tail_reg;
                nxt_wdata                   = free_idx_reg;
                free_map_next[free_idx_reg] = 1'b0;
                tail_next                   = free_idx_reg;
                count_next                  = count_reg + CNT_W'(1);
            end
            OP_INS_MID_A: begin
                val_we    = 1'b1;
                nxt_we    = 1'b1;
                nxt_wdata = nxt_rdata;
            end
            OP_INS_MID_B: begin
                nxt_we                      = 1'b1;
                nxt_waddr                   = cur_reg;
                nxt_wdata                   = free_idx_reg;
                free_map_next[free_idx_reg] = 1'b0;
                count_next                  = count_reg + CNT_W'(1);
            end
            OP_DEL_HEAD: begin
                free_map_next[cur_reg] = 1'b1;
                count_next             = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next = nxt_rdata;
                end
            end
            OP_DEL_STEP: begin
                prev_next = cur_reg;
                cur_next  = nxt_rdata;
            end
            OP_DEL_LINK: begin
                nxt_we                 = 1'b1;
                nxt_waddr              = prev_reg;
                nxt_wdata              = nxt_rdata;
                free_map_next[cur_reg] = 1'b1;
                count_next             = count_reg - CNT_W'(1);
                if (cur_reg == tail_reg) begin
                    tail_next = prev_reg;
                end
            end
            OP_RD_ITEM: begin
                out_valid_next  = 1'b1;
                out_value_next  = ITEM_W'(val_rdata);
                out_index_next  = IDX_W'(idx_reg);
                out_status_next = RES_OK;
                out_last_next   = (idx_reg == count_reg);
                out_count_next  = IDX_W'(count_reg);
                cur_next        = nxt_rdata;
                idx_next        = idx_reg + CNT_W'(1);
            end
            OP_RESULT: begin
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                out_index_next  = '0;
                out_status_next = ctl.result;
                out_last_next   = 1'b1;
                out_count_next  = IDX_W'(count_reg);
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_map_reg  <= '1;
            free_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_map_reg  <= free_map_next;
            free_idx_reg  <= free_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        idx_reg        <= idx_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_out_value  = out_value_reg;
    assign m_out_index  = out_index_reg;
    assign m_status     = out_status_reg;
    assign m_last       = out_last_reg;
    assign m_list_count = out_count_reg;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import plle_pkg::*;

    localparam int LIST_DEPTH = DEFAULT_LIST_DEPTH;
    localparam int RANDOM_ITEMS = 254;
    localparam int BURST_LEN = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 60;
    localparam int CALM_FIRST = 150;
    localparam int CALM_LAST = 210;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int MAX_REPORTS = 10;

    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    typedef struct {
        logic [ITEM_W-1:0]   value;
        logic [IDX_W-1:0]    index;
        logic [STATUS_W-1:0] status;
        logic                is_last;
        logic [IDX_W-1:0]    count;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [POS_W-1:0]    pos;
        logic [ITEM_W-1:0]   value;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    count;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic        [CMD_W-1:0]      s_cmd;
    logic        [POS_W-1:0]      s_position;
    logic signed [ITEM_W-1:0]     s_item_value;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [ITEM_W-1:0]     m_out_value;
    logic        [IDX_W-1:0]      m_out_index;
    logic        [STATUS_W-1:0]   m_status;
    logic                         m_last;
    logic        [IDX_W-1:0]      m_list_count;

    logic [ITEM_W-1:0] node_value [LIST_DEPTH];
    logic [4:0]        node_next [LIST_DEPTH];
    bit                node_free [LIST_DEPTH];
    logic [4:0]        head_node;
    logic [4:0]        tail_node;
    int                list_len;

    list_result_t expected_results [$];
    int           items_sent;
    int           mismatch_count;
    int           idle_cycles;

    stim_row_t directed_rows [26] = '{
        '{CMD_READ,     6'd0,  32'h0000_0000, 1'b1, RES_EMPTY, 6'd0},
        '{CMD_DEL_POS,  6'd1,  32'h0000_0000, 1'b1, RES_RANGE, 6'd0},
        '{CMD_INS_POS,  6'd0,  32'h1111_1111, 1'b1, RES_RANGE, 6'd0},
        '{CMD_INS_POS,  6'd2,  32'h2222_2222, 1'b1, RES_RANGE, 6'd0},
        '{CMD_INS_TAIL, 6'd0,  32'h7FFF_FFFF, 1'b1, RES_OK,    6'd1},
        '{CMD_INS_HEAD, 6'd63, 32'h8000_0000, 1'b1, RES_OK,    6'd2},
        '{CMD_INS_POS,  6'd3,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_INS_POS,  6'd2,  32'hFFFF_FFFF, 1'b0, RES_OK,    6'd0},
        '{CMD_INS_POS,  6'd1,  32'h5555_5555, 1'b0, RES_OK,    6'd0},
        '{CMD_READ,     6'd0,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd5,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_INS_TAIL, 6'd0,  32'hAAAA_AAAA, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd3,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd1,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd4,  32'h0000_0000, 1'b1, RES_RANGE, 6'd3},
        '{CMD_DEL_POS,  6'd0,  32'h0000_0000, 1'b1, RES_RANGE, 6'd3},
        '{CMD_INS_POS,  6'd63, 32'h3333_3333, 1'b1, RES_RANGE, 6'd3},
        '{CMD_SPARE_5,  6'd63, 32'h1234_5678, 1'b1, RES_OK,    6'd3},
        '{CMD_SPARE_6,  6'd1,  32'hFFFF_FFFF, 1'b1, RES_OK,    6'd3},
        '{CMD_SPARE_7,  6'd2,  32'h8000_0000, 1'b1, RES_OK,    6'd3},
        '{CMD_READ,     6'd0,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd1,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd1,  32'h0000_0000, 1'b0, RES_OK,    6'd0},
        '{CMD_DEL_POS,  6'd1,  32'h0000_0000, 1'b1, RES_OK,    6'd0},
        '{CMD_READ,     6'd0,  32'h0000_0000, 1'b1, RES_EMPTY, 6'd0},
        '{CMD_INS_POS,  6'd1,  32'h0000_0001, 1'b1, RES_OK,    6'd1}
    };

    positional_linked_list_engine_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_index  (m_out_index),
        .m_status     (m_status),
        .m_last       (m_last),
        .m_list_count (m_list_count)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic bit in_calm_stretch();
        return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
    endfunction

    function automatic void expect_result(logic [ITEM_W-1:0] value, int index,
                                          logic [STATUS_W-1:0] status, logic is_last);
        list_result_t res;
        res.value = value;
        res.index = index[IDX_W-1:0];
        res.status = status;
        res.is_last = is_last;
        res.count = list_len[IDX_W-1:0];
        expected_results.push_back(res);
    endfunction

    function automatic logic [4:0] claim_node(logic [ITEM_W-1:0] value);
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (node_free[i]) begin
                node_free[i] = 1'b0;
                node_value[i] = value;
                node_next[i] = '0;
                return i[4:0];
            end
        end
        return '0;
    endfunction

    function automatic logic [4:0] node_at(int steps);
        logic [4:0] node;
        node = head_node;
        for (int i = 0; i < steps; i++) begin
            node = node_next[node];
        end
        return node;
    endfunction

    function automatic void link_at_head(logic [ITEM_W-1:0] value);
        logic [4:0] node;
        node = claim_node(value);
        if (list_len == 0) begin
            tail_node = node;
        end else begin
            node_next[node] = head_node;
        end
        head_node = node;
        list_len++;
    endfunction

    function automatic void link_at_tail(logic [ITEM_W-1:0] value);
        logic [4:0] node;
        if (list_len == 0) begin
            link_at_head(value);
        end else begin
            node = claim_node(value);
            node_next[tail_node] = node;
            tail_node = node;
            list_len++;
        end
    endfunction

    function automatic void predict_list_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                                 logic [ITEM_W-1:0] value);
        logic [4:0]          node;
        logic [4:0]          prev;
        logic [STATUS_W-1:0] status;
        int                  p;
        status = RES_OK;
        p = int'(pos);
        if (cmd == CMD_READ) begin
            if (list_len == 0) begin
                expect_result('0, 0, RES_EMPTY, 1'b1);
            end else begin
                node = head_node;
                for (int k = 0; k < list_len; k++) begin
                    expect_result(node_value[node], k + 1, RES_OK, k + 1 == list_len);
                    node = node_next[node];
                end
            end
        end else begin
            if (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL || cmd == CMD_INS_POS) begin
                if (list_len >= LIST_DEPTH) begin
                    status = RES_FULL;
                end else if (cmd == CMD_INS_HEAD) begin
                    link_at_head(value);
                end else if (cmd == CMD_INS_TAIL) begin
                    link_at_tail(value);
                end else if (p == 0 || p > list_len + 1) begin
                    status = RES_RANGE;
                end else if (p == 1) begin
                    link_at_head(value);
                end else if (p == list_len + 1) begin
                    link_at_tail(value);
                end else begin
                    prev = node_at(p - 2);
                    node = claim_node(value);
                    node_next[node] = node_next[prev];
                    node_next[prev] = node;
                    list_len++;
                end
            end else if (cmd == CMD_DEL_POS) begin
                if (p == 0 || p > list_len) begin
                    status = RES_RANGE;
                end else if (p == 1) begin
                    node = head_node;
                    node_free[node] = 1'b1;
                    list_len--;
                    if (list_len == 0) begin
                        head_node = '0;
                        tail_node = '0;
                    end else begin
                        head_node = node_next[node];
                    end
                end else begin
                    prev = node_at(p - 2);
                    node = node_next[prev];
                    node_next[prev] = node_next[node];
                    if (node == tail_node) begin
                        tail_node = prev;
                    end
                    node_free[node] = 1'b1;
                    list_len--;
                end
            end
            expect_result('0, 0, status, 1'b1);
        end
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [ITEM_W-1:0] value, input bit typed,
                                input logic [STATUS_W-1:0] t_status,
                                input logic [IDX_W-1:0] t_count);
        list_result_t typed_res;
        if (!in_calm_stretch() && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_position <= pos;
        s_item_value <= value;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        items_sent++;
        predict_list_command(cmd, pos, value);
        if (typed) begin
            void'(expected_results.pop_back());
            typed_res.value = '0;
            typed_res.index = '0;
            typed_res.status = t_status;
            typed_res.is_last = 1'b1;
            typed_res.count = t_count;
            expected_results.push_back(typed_res);
        end
    endtask

    function automatic logic [ITEM_W-1:0] random_value();
        logic [ITEM_W-1:0] corner [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        if ($urandom_range(9) == 0) begin
            return corner[$urandom_range(3)];
        end
        return $urandom;
    endfunction

    initial begin
        mix_t              mix;
        int                pick;
        int                span;
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [CMD_W-1:0]  insert_cmds [3];
        logic [CMD_W-1:0]  spare_cmds [3];
        insert_cmds = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS};
        spare_cmds = '{CMD_SPARE_5, CMD_SPARE_6, CMD_SPARE_7};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd <= '0;
        s_position <= '0;
        s_item_value <= '0;
        items_sent = 0;
        list_len = 0;
        head_node = '0;
        tail_node = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            node_free[i] = 1'b1;
            node_value[i] = '0;
            node_next[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].status,
                         directed_rows[i].count);
        end

        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BURST_LEN == 0) begin
                if (n < 3 * BURST_LEN) begin
                    mix = ((n / BURST_LEN) % 2) ? MIX_DRAIN : MIX_FILL;
                end else begin
                    mix = mix_t'($urandom_range(2));
                end
            end
            pick = $urandom_range(99);
            case (mix)
                MIX_FILL:  pick = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 92) ? 2 : 3;
                MIX_DRAIN: pick = (pick < 15) ? 0 : (pick < 25) ? 1 : (pick < 92) ? 2 : 3;
                default:   pick = (pick < 40) ? 0 : (pick < 55) ? 1 : (pick < 92) ? 2 : 3;
            endcase
            pos = POS_W'($urandom_range(63));
            case (pick)
                0: begin
                    cmd = insert_cmds[$urandom_range(2)];
                    if ($urandom_range(9) != 0) begin
                        pos = POS_W'($urandom_range(1, list_len + 1));
                    end
                end
                1: cmd = CMD_READ;
                2: begin
                    cmd = CMD_DEL_POS;
                    if (list_len > 0 && $urandom_range(9) != 0) begin
                        pos = POS_W'($urandom_range(1, list_len));
                    end
                end
                default: cmd = spare_cmds[$urandom_range(2)];
            endcase
            send_command(cmd, pos, random_value(), 1'b0, RES_OK, '0);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        do begin
            @(posedge aclk);
        end while (!aresetn);
        forever begin
            if (!held && items_sent >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= in_calm_stretch() || $urandom_range(99) >= 15;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result transfer: value %h index %0d status %0d",
                             m_out_value, m_out_index, m_status);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_out_value !== want.value || m_out_index !== want.index
                        || m_status !== want.status || m_last !== want.is_last
                        || m_list_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"result mismatch: expected value %h index %0d",
                                  " status %0d last %0d count %0d"},
                                 want.value, want.index, want.status, want.is_last,
                                 want.count);
                        $display({"                 actual   value %h index %0d",
                                  " status %0d last %0d count %0d"},
                                 m_out_value, m_out_index, m_status, m_last,
                                 m_list_count);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
    end

endmodule
